// ----- rtl/cesd_pkg.sv -----
// Package for the C escape sequence decoder: decode modes, result status codes,
// character constants and the hex digit helper. No dependencies.
package cesd_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX1 = 2'd2,
    MODE_HEX2 = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_BADHEX  = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_LC_N      = 8'h6E;
  localparam logic [7:0] CH_UC_N      = 8'h4E;
  localparam logic [7:0] CH_LC_T      = 8'h74;
  localparam logic [7:0] CH_UC_T      = 8'h54;
  localparam logic [7:0] CH_LC_R      = 8'h72;
  localparam logic [7:0] CH_UC_R      = 8'h52;
  localparam logic [7:0] CH_LC_X      = 8'h78;
  localparam logic [7:0] CH_UC_X      = 8'h58;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef struct packed {
    logic [3:0] value;
    logic       bad;
  } hex_digit_t;

  // Value of one ASCII hex digit; anything else reads as zero and is marked bad.
  function automatic hex_digit_t hex_value(input logic [7:0] b);
    hex_digit_t r;
    r.value = 4'd0;
    r.bad   = 1'b0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.value = 4'(b - 8'h37);
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/cesd_if.sv -----
// Stream interfaces of the C escape sequence decoder: raw input words and
// decoded result words, each with a valid/ready handshake. No dependencies.
interface cesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface cesd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       end_of_string;

  modport source (output valid, output out_byte, output status, output end_of_string,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input end_of_string,
                  output ready);
endinterface

// ----- rtl/c_escape_sequence_decoder_core.sv -----
// C escape sequence decoder, top level: input register, decode logic, result register.
// Depends on cesd_pkg and the stream interfaces in cesd_if.sv.
//
// This block takes the body of a C-style string one byte per word and returns the
// decoded bytes. A backslash opens an escape: n, t and r in either case give newline,
// tab and carriage return; backslash and both quote characters give themselves; x or X
// takes exactly two hex digits, high nibble first, and a digit that is not hex counts
// as zero and gives status 2 (bad hex digit). Any other escaped byte comes out as
// itself with status 1 (unknown escape). The backslash, the x and the first hex digit
// give no result word of their own. When the word marked last_byte leaves an escape
// open, the block returns byte 0 with status 3 (truncated escape). Every last word
// yields a result with end_of_string set, and the decoder then starts fresh. The block
// takes one word per clock cycle while no result waits at the output. Each word is
// held in the input register and is decoded into the result register as it leaves.
// A result that waits on the output side stalls only the input register; new words
// keep arriving while the register has room.
module c_escape_sequence_decoder_core (
  input  logic        clk,
  input  logic        rst,
  cesd_in_if.sink     in_ch,
  cesd_out_if.source  out_ch
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Decode state.
  cesd_pkg::mode_t mode;
  logic [3:0]      high_nibble;
  logic            hex_err;

  // Result register.
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_eos;

  // Decode outputs.
  logic                 emit;
  logic [7:0]           res_byte;
  cesd_pkg::status_t    res_status;
  cesd_pkg::mode_t      mode_next;
  logic [3:0]           high_nibble_next;
  logic                 hex_err_next;
  cesd_pkg::hex_digit_t digit;

  logic out_free;
  logic advance;

  // The held word moves on when the result register is empty or being emptied.
  assign out_free = !out_valid || out_ch.ready;
  assign advance  = in_valid && out_free;
  assign in_ch.ready = !in_valid || out_free;

  assign digit = cesd_pkg::hex_value(in_byte);

  always_comb begin
    emit             = 1'b0;
    res_byte         = in_byte;
    res_status       = cesd_pkg::ST_OK;
    mode_next        = mode;
    high_nibble_next = high_nibble;
    hex_err_next     = hex_err;
    case (mode)
      cesd_pkg::MODE_TEXT: begin
        if (in_byte == cesd_pkg::CH_BACKSLASH) begin
          mode_next = cesd_pkg::MODE_ESC;
        end else begin
          emit = 1'b1;
        end
      end
      cesd_pkg::MODE_ESC: begin
        mode_next = cesd_pkg::MODE_TEXT;
        emit      = 1'b1;
        case (in_byte)
          cesd_pkg::CH_LC_N, cesd_pkg::CH_UC_N: res_byte = cesd_pkg::CH_NEWLINE;
          cesd_pkg::CH_LC_T, cesd_pkg::CH_UC_T: res_byte = cesd_pkg::CH_TAB;
          cesd_pkg::CH_LC_R, cesd_pkg::CH_UC_R: res_byte = cesd_pkg::CH_CR;
          cesd_pkg::CH_BACKSLASH, cesd_pkg::CH_DQUOTE, cesd_pkg::CH_SQUOTE: begin
            res_byte = in_byte;
          end
          cesd_pkg::CH_LC_X, cesd_pkg::CH_UC_X: begin
            emit             = 1'b0;
            mode_next        = cesd_pkg::MODE_HEX1;
            high_nibble_next = 4'd0;
            hex_err_next     = 1'b0;
          end
          default: res_status = cesd_pkg::ST_UNKNOWN;
        endcase
      end
      cesd_pkg::MODE_HEX1: begin
        mode_next        = cesd_pkg::MODE_HEX2;
        high_nibble_next = digit.value;
        hex_err_next     = digit.bad;
      end
      default: begin
        emit             = 1'b1;
        res_byte         = {high_nibble, digit.value};
        res_status       = (hex_err || digit.bad) ? cesd_pkg::ST_BADHEX : cesd_pkg::ST_OK;
        mode_next        = cesd_pkg::MODE_TEXT;
        high_nibble_next = 4'd0;
        hex_err_next     = 1'b0;
      end
    endcase
    // The last word always yields a result; an open escape is reported as truncated.
    if (in_last) begin
      if (!emit) begin
        res_byte   = 8'd0;
        res_status = cesd_pkg::ST_TRUNC;
      end
      emit             = 1'b1;
      mode_next        = cesd_pkg::MODE_TEXT;
      high_nibble_next = 4'd0;
      hex_err_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      mode        <= cesd_pkg::MODE_TEXT;
      high_nibble <= 4'd0;
      hex_err     <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid <= in_ch.valid;
      end
      if (advance) begin
        mode        <= mode_next;
        high_nibble <= high_nibble_next;
        hex_err     <= hex_err_next;
      end
      if (out_free) begin
        out_valid <= advance && emit;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte <= in_ch.in_byte;
      in_last <= in_ch.last_byte;
    end
    if (advance && emit) begin
      out_byte   <= res_byte;
      out_status <= res_status;
      out_eos    <= in_last;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.out_byte      = out_byte;
  assign out_ch.status        = out_status;
  assign out_ch.end_of_string = out_eos;

`ifndef SYNTHESIS
  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid after reset");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (mode == cesd_pkg::MODE_TEXT && high_nibble == 4'd0 && !hex_err))
    else $error("decoder state not cleared after last word");

  a_trunc_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == cesd_pkg::ST_TRUNC) |-> (out_eos && out_byte == 8'd0))
    else $error("truncated escape result malformed");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (out_valid && out_eos))
    else $error("last word produced no end-of-string result");
`endif

endmodule
